@@ sv/ulsm_pkg.sv @@
`timescale 1ns / 1ps

package ulsm_pkg;

	localparam int LINE_W     = 9;
	localparam int INV_W      = 4;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int EV_MAX     = 4;
	localparam int EV_CNT_W   = 3;

	typedef enum logic [2:0] {
		EV_POWER_OK  = 3'd0,
		EV_LINE_FAIL = 3'd1,
		EV_LOW_BATT  = 3'd2,
		EV_CABLE     = 3'd3,
		EV_CONN_OK   = 3'd4
	} event_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POWER_MASK   = 3'd0,
		REG_BATTERY_MASK = 3'd1,
		REG_RESERVE_MASK = 3'd2,
		REG_CABLE_MASK   = 3'd3,
		REG_LINE_INVERT  = 3'd4,
		REG_MODEL_VAR    = 3'd5
	} cfg_reg_t;

	// Bit positions inside line_invert.
	localparam int INV_POWER   = 0;
	localparam int INV_BATTERY = 1;
	localparam int INV_RESERVE = 2;
	localparam int INV_CABLE   = 3;

	typedef struct packed {
		logic [LINE_W-1:0] power_mask;
		logic [LINE_W-1:0] battery_mask;
		logic [LINE_W-1:0] reserve_mask;
		logic [LINE_W-1:0] cable_mask;
		logic [INV_W-1:0]  invert;
		logic              model_variant;
	} cfg_t;

	typedef struct packed {
		logic power;
		logic battery;
		logic connect;
		logic cable;
		logic cable_used;
	} levels_t;

	typedef struct packed {
		event_code_t [EV_MAX-1:0] code;
		logic [EV_CNT_W-1:0]      cnt;
	} ev_bundle_t;

endpackage

@@ sv/ulsm_levels.sv @@
`timescale 1ns / 1ps

module ulsm_levels import ulsm_pkg::*; (
	input  cfg_t              cfg,
	input  logic [LINE_W-1:0] flags,
	output levels_t           lv
);

	// A line with no mask bits reads as normal; otherwise any selected bit
	// counts as active, and the invert flag makes the line active low.
	function automatic logic line_level(input logic [LINE_W-1:0] mask,
		input logic inv, input logic [LINE_W-1:0] fl);
		logic active;
		active = |(mask & fl);
		return (mask == '0) ? 1'b1 : (active ^ inv);
	endfunction

	logic reserve;

	always_comb begin
		lv.power      = line_level(cfg.power_mask, cfg.invert[INV_POWER], flags);
		lv.battery    = line_level(cfg.battery_mask, cfg.invert[INV_BATTERY], flags);
		reserve       = line_level(cfg.reserve_mask, cfg.invert[INV_RESERVE], flags);
		lv.connect    = lv.power | lv.battery | reserve;
		lv.cable      = line_level(cfg.cable_mask, cfg.invert[INV_CABLE], flags);
		lv.cable_used = (cfg.cable_mask != '0);
	end

endmodule

@@ sv/ulsm_core.sv @@
`timescale 1ns / 1ps

module ulsm_core import ulsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  levels_t    lv,
	input  logic       commit,
	output ev_bundle_t ev
);

	logic       power_prev_q, battery_prev_q, connect_prev_q, cable_wait_q;
	logic [2:0] pending_q;

	logic       power_prev_d, battery_prev_d, connect_prev_d, cable_wait_d;
	logic [2:0] pending_d;

	always_comb begin
		logic                p, b, c, run;
		logic [EV_CNT_W-1:0] n;
		event_code_t [EV_MAX-1:0] codes;

		power_prev_d   = power_prev_q;
		battery_prev_d = battery_prev_q;
		connect_prev_d = connect_prev_q;
		cable_wait_d   = cable_wait_q;
		pending_d      = pending_q;
		codes          = '{default: EV_POWER_OK};
		n              = '0;
		run            = 1'b0;
		p              = lv.power;
		b              = lv.battery;
		c              = lv.connect;

		if (cable_wait_q) begin
			// A held tick only re-tests the cable line; once it reads ok the
			// stored levels are processed as if they came with this tick.
			if (lv.cable) begin
				cable_wait_d = 1'b0;
				p            = pending_q[0];
				b            = pending_q[1];
				c            = pending_q[2];
				run          = 1'b1;
			end
		end else if (lv.cable_used) begin
			if (c != connect_prev_q && !lv.cable) begin
				pending_d    = {c, b, p};
				cable_wait_d = 1'b1;
			end else begin
				run = 1'b1;
			end
		end else begin
			run = 1'b1;
			if (c != connect_prev_q) begin
				if (c) begin
					codes[n[1:0]] = EV_CONN_OK;
					n             = n + 1'b1;
					if (!b && !p) begin
						codes[n[1:0]] = EV_LOW_BATT;
						n             = n + 1'b1;
					end else if (!p) begin
						codes[n[1:0]] = EV_LINE_FAIL;
						n             = n + 1'b1;
					end
				end else begin
					// Without a cable line a lost connection is a cable fault;
					// the levels are taken over silently.
					power_prev_d   = p;
					battery_prev_d = b;
					codes[n[1:0]]  = EV_CABLE;
					n              = n + 1'b1;
				end
			end
		end

		if (run) begin
			if (c && (p != power_prev_d || b != battery_prev_d)) begin
				if (p != power_prev_d) begin
					codes[n[1:0]] = p ? EV_POWER_OK : (b ? EV_LINE_FAIL : EV_LOW_BATT);
					n             = n + 1'b1;
				end
				if (b != battery_prev_d) begin
					if (!b && !p) begin
						codes[n[1:0]] = EV_LOW_BATT;
						n             = n + 1'b1;
					end else if (!cfg.model_variant) begin
						codes[n[1:0]] = (b && !p) ? EV_LINE_FAIL : EV_POWER_OK;
						n             = n + 1'b1;
					end
				end
				power_prev_d   = p;
				battery_prev_d = b;
			end
			connect_prev_d = c;
		end

		ev.code = codes;
		ev.cnt  = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_prev_q   <= 1'b1;
			battery_prev_q <= 1'b1;
			connect_prev_q <= 1'b1;
			cable_wait_q   <= 1'b0;
			pending_q      <= '0;
		end else if (commit) begin
			power_prev_q   <= power_prev_d;
			battery_prev_q <= battery_prev_d;
			connect_prev_q <= connect_prev_d;
			cable_wait_q   <= cable_wait_d;
			pending_q      <= pending_d;
		end
	end

endmodule

@@ sv/ulsm_evq.sv @@
`timescale 1ns / 1ps

module ulsm_evq import ulsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ev_bundle_t        bundle,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        event_code,
	output logic              last_event
);

	event_code_t [EV_MAX-1:0] code_q;
	logic [EV_CNT_W-1:0]      cnt_q;
	logic                     pop;

	assign out_valid  = (cnt_q != '0);
	assign pop        = out_valid && out_ready;
	assign free       = (cnt_q == '0) || (cnt_q == EV_CNT_W'(1) && out_ready);
	assign event_code = code_q[0];
	assign last_event = (cnt_q == EV_CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= bundle.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= bundle.code;
		end else if (pop) begin
			for (int i = 0; i < EV_MAX - 1; i++) begin
				code_q[i] <= code_q[i+1];
			end
			code_q[EV_MAX-1] <= EV_POWER_OK;
		end
	end

endmodule

@@ sv/ups_line_status_monitor.sv @@
`timescale 1ns / 1ps
// A tick accepted into the input register is evaluated there by the rule
// logic; on commit its events load the registered event queue, which offers
// the first on the output. Throughput: one tick per cycle while out_ready
// holds and ticks give at most one event; a tick with several events holds
// back the next tick with events until the one-event-per-cycle output queue
// is down to its last event. Reset zeroes the configuration, sets line history
// to "power ok, battery ok, connected", and empties the input and event stages.

module ups_line_status_monitor import ulsm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [LINE_W-1:0]     line_flags,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            event_code,
	output logic                  last_event,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers. Writes to unused indexes are dropped.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POWER_MASK:   cfg_q.power_mask    <= cfg_data;
				REG_BATTERY_MASK: cfg_q.battery_mask  <= cfg_data;
				REG_RESERVE_MASK: cfg_q.reserve_mask  <= cfg_data;
				REG_CABLE_MASK:   cfg_q.cable_mask    <= cfg_data;
				REG_LINE_INVERT:  cfg_q.invert        <= cfg_data[INV_W-1:0];
				REG_MODEL_VAR:    cfg_q.model_variant <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register: holds the sampled line bits of one tick until the
	// rule logic can commit it.
	logic [LINE_W-1:0] flags_s1;
	logic              valid_s1;
	logic              commit;
	logic              q_free;
	levels_t           lv;
	ev_bundle_t        ev;

	// A tick commits when it gives no event, or when the event queue is empty
	// or hands over its last event in this same cycle. Ticks without events
	// only update the line history and never wait on the output.
	assign commit   = valid_s1 && ((ev.cnt == '0) || q_free);
	assign in_ready = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			flags_s1 <= line_flags;
		end
	end

	// Mask and invert decoding of the modem lines.
	ulsm_levels u_levels (
		.cfg   (cfg_q),
		.flags (flags_s1),
		.lv    (lv)
	);

	// Transition rules and line history, including the cable hold.
	ulsm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.lv     (lv),
		.commit (commit),
		.ev     (ev)
	);

	// Event queue: the registered output stage, one event transfer per cycle while out_ready is high.
	ulsm_evq u_evq (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (commit && (ev.cnt != '0)),
		.bundle     (ev),
		.free       (q_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_code (event_code),
		.last_event (last_event)
	);

endmodule
